// File: sv/bftc_pkg.sv
// Shared types and constants for the bitmap font text console.
// No dependencies; imported by bftc_cfg, bftc_seq, the top level and bftc_chk.
package bftc_pkg;

    // Font geometry
    localparam int GLYPH_ROWS      = 16;
    localparam int GLYPH_WIDTH     = 8;
    localparam int GLYPH_COUNT     = 256;
    localparam int STORE_DEPTH     = GLYPH_COUNT * GLYPH_ROWS;
    localparam int SLOT_W          = $clog2(STORE_DEPTH);
    localparam int CODE_W          = $clog2(GLYPH_COUNT);
    localparam int ROW_W           = $clog2(GLYPH_ROWS);
    localparam int NEWLINE_ADVANCE = 16;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] NULL_CODE    = 8'd0;
    // Only the leftmost GLYPH_WIDTH pixels of a row are painted
    localparam logic [7:0] VIS_MASK     = 8'(8'hFF << (8 - GLYPH_WIDTH));

    // Register file
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIXEL_COLOR  = 3'd0,
        CFG_FRAME_BASE   = 3'd1,
        CFG_SCAN_STRIDE  = 3'd2,
        CFG_SCREEN_WIDTH = 3'd3,
        CFG_HOME_X       = 3'd4,
        CFG_HOME_Y       = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [31:0] pixel_color;
        logic [31:0] frame_base;
        logic [13:0] scan_stride;
        logic [13:0] screen_width;
        logic [12:0] home_x;
        logic [15:0] home_y;
    } t_cfg;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_PRINT = 2'd1,
        OP_HOME  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_BASE,
        ST_ROWS
    } t_state;

endpackage

// File: sv/bftc_in_if.sv
// Command channel interface: load / print / home items.
// Standalone; field widths fixed by the command format.
interface bftc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [11:0] glyph_slot;
    logic [7:0]  glyph_byte;
    logic [7:0]  char_code;

    modport source (output valid, op, glyph_slot, glyph_byte, char_code, input ready);
    modport sink   (input valid, op, glyph_slot, glyph_byte, char_code, output ready);
endinterface

// File: sv/bftc_out_if.sv
// Pixel row channel interface: one glyph row per transfer.
// Standalone; field widths fixed by the result format.
interface bftc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] row_address;
    logic [7:0]  row_mask;
    logic [31:0] ink_color;
    logic        last_row;

    modport source (output valid, row_address, row_mask, ink_color, last_row, input ready);
    modport sink   (input valid, row_address, row_mask, ink_color, last_row, output ready);
endinterface

// File: sv/bftc_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module bftc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/bftc_cfg.sv
// Configuration register file: color, framebuffer geometry, home cursor.
// Depends on bftc_pkg.
module bftc_cfg import bftc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_color  <= 32'hFFFF_FFFF;
            r_cfg.frame_base   <= 32'd0;
            r_cfg.scan_stride  <= 14'd1024;
            r_cfg.screen_width <= 14'd1024;
            r_cfg.home_x       <= 13'd0;
            r_cfg.home_y       <= 16'd0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_PIXEL_COLOR:  r_cfg.pixel_color  <= i_cfg_data;
                CFG_FRAME_BASE:   r_cfg.frame_base   <= i_cfg_data;
                CFG_SCAN_STRIDE:  r_cfg.scan_stride  <= i_cfg_data[13:0];
                CFG_SCREEN_WIDTH: r_cfg.screen_width <= i_cfg_data[13:0];
                CFG_HOME_X:       r_cfg.home_x       <= i_cfg_data[12:0];
                CFG_HOME_Y:       r_cfg.home_y       <= i_cfg_data[15:0];
                default: ;  // unmapped index
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: sv/bftc_seq.sv
// Item sequencer: cursor, row address generation, glyph row read-out.
// Depends on bftc_pkg, bftc_in_if, bftc_out_if; drives the glyph RAM ports.
module bftc_seq import bftc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    bftc_in_if.sink           i_cmd,
    bftc_out_if.source        o_pix,
    output logic              o_ram_we,
    output logic [SLOT_W-1:0] o_ram_waddr,
    output logic [7:0]        o_ram_wdata,
    output logic [SLOT_W-1:0] o_ram_raddr,
    input  logic [7:0]        i_ram_rdata
);

    t_state r_state, n_state;

    logic [12:0]       r_cx;
    logic [15:0]       r_cy;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [CODE_W-1:0] r_code;
    logic [29:0]       r_prod;
    logic [31:0]       r_addr;

    logic              r_ov;
    logic [31:0]       r_oaddr;
    logic [7:0]        r_omask;
    logic [31:0]       r_ocolor;
    logic              r_olast;

    logic              w_acc;
    logic              w_draw;
    logic              w_fire;
    logic              w_last;
    logic [13:0]       w_nx;
    logic              w_wrap;

    assign w_acc  = i_cmd.valid && i_cmd.ready;
    // printable character: print op, not null, not newline
    assign w_draw = (t_op'(i_cmd.op) == OP_PRINT) && (i_cmd.char_code != NULL_CODE)
                    && (i_cmd.char_code != NEWLINE_CODE);
    assign w_last = (r_row == ROW_W'(GLYPH_ROWS - 1));
    assign w_nx   = {1'b0, r_cx} + 14'(GLYPH_WIDTH);
    assign w_wrap = (w_nx >= i_cfg.screen_width);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_acc && w_draw) n_state = ST_MUL;
            ST_MUL:  n_state = ST_BASE;
            ST_BASE: n_state = ST_ROWS;
            ST_ROWS: if (w_fire && w_last) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        i_cmd.ready = 1'b0;
        w_fire      = 1'b0;
        case (r_state)
            ST_IDLE: i_cmd.ready = 1'b1;
            ST_ROWS: w_fire = !r_ov || o_pix.ready;
            default: ;
        endcase
    end

    // The next row value addresses the RAM so the registered read data is ready at fire
    always_comb begin
        n_row = r_row;
        if (w_fire) begin
            n_row = w_last ? '0 : r_row + ROW_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row   <= '0;
            r_cx    <= '0;
            r_cy    <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;

            if (w_acc) begin
                case (t_op'(i_cmd.op))
                    OP_HOME: begin
                        r_cx <= i_cfg.home_x;
                        r_cy <= i_cfg.home_y;
                    end
                    OP_PRINT: begin
                        if (i_cmd.char_code == NEWLINE_CODE) begin
                            r_cx <= '0;
                            r_cy <= r_cy + 16'(NEWLINE_ADVANCE);
                        end
                    end
                    default: ;
                endcase
            end

            // cursor advance after the final row
            if (w_fire && w_last) begin
                if (w_wrap) begin
                    r_cx <= '0;
                    r_cy <= r_cy + 16'(GLYPH_ROWS);
                end else begin
                    r_cx <= w_nx[12:0];
                end
            end

            if (w_fire) begin
                r_ov <= 1'b1;
            end else if (o_pix.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (w_acc && w_draw) begin
            r_code <= i_cmd.char_code[CODE_W-1:0];
        end
        if (r_state == ST_MUL) begin
            r_prod <= 30'(r_cy) * 30'(i_cfg.scan_stride);
        end
        if (r_state == ST_BASE) begin
            r_addr <= i_cfg.frame_base + 32'(r_cx) + 32'(r_prod);
        end else if (w_fire) begin
            r_addr <= r_addr + 32'(i_cfg.scan_stride);
        end
        if (w_fire) begin
            r_oaddr  <= r_addr;
            r_omask  <= i_ram_rdata & VIS_MASK;
            r_ocolor <= i_cfg.pixel_color;
            r_olast  <= w_last;
        end
    end

    assign o_ram_we    = w_acc && (t_op'(i_cmd.op) == OP_LOAD);
    assign o_ram_waddr = i_cmd.glyph_slot[SLOT_W-1:0];
    assign o_ram_wdata = i_cmd.glyph_byte;
    assign o_ram_raddr = {r_code, n_row};

    assign o_pix.valid       = r_ov;
    assign o_pix.row_address = r_oaddr;
    assign o_pix.row_mask    = r_omask;
    assign o_pix.ink_color   = r_ocolor;
    assign o_pix.last_row    = r_olast;

endmodule

// File: sv/bitmap_font_text_console.sv
// Top level of the bitmap font text console: glyph RAM, registers, sequencer.
// Depends on bftc_pkg, bftc_in_if, bftc_out_if, bftc_ram, bftc_cfg, bftc_seq.
//
//  Port      Dir  Handshake        Moves
//  --------  ---  ---------------  -------------------------------------------
//  i_cmd     in   valid/ready      op, glyph_slot, glyph_byte, char_code
//  o_pix     out  valid/ready      row_address, row_mask, ink_color, last_row
//  i_cfg_*   in   write enable     register index, 32-bit write data
//
//  Load, home, newline, null and unused-op commands never stall the channel.
//  A printed character is accepted, then the cursor_y * scan_stride product is
//  formed, then the base address is added, then one glyph row a cycle goes
//  out of the single read port of the glyph RAM while o_pix does not stall.
//  Reset is synchronous, active low; the glyph RAM is not cleared and needs
//  no clearing pass. A stall on o_pix holds the row sequencer; the next
//  command is taken while the last row of a character still waits to go out.
module bitmap_font_text_console import bftc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bftc_in_if.sink               i_cmd,
    bftc_out_if.source            o_pix,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg              w_cfg;
    logic              w_ram_we;
    logic [SLOT_W-1:0] w_ram_waddr;
    logic [7:0]        w_ram_wdata;
    logic [SLOT_W-1:0] w_ram_raddr;
    logic [7:0]        w_ram_rdata;

    // Register file; the user must write it only while no transfer is in flight (not enforced)
    bftc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // Glyph store: 8-bit rows, character * GLYPH_ROWS + row
    bftc_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_glyph_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // Cursor, addressing and row read-out
    bftc_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd       (i_cmd),
        .o_pix       (o_pix),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata)
    );

endmodule

// File: sv/bftc_chk.sv
// Port-level checks for the bitmap font text console, bound to the top level.
// Depends on bftc_pkg and bitmap_font_text_console.
module bftc_chk import bftc_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic [1:0] i_in_op,
    input logic [7:0] i_in_char,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_out_last
);

    logic w_in_xfer;
    logic w_draw;

    assign w_in_xfer = i_in_valid && i_in_ready;
    assign w_draw    = (i_in_op == OP_PRINT) && (i_in_char != NULL_CODE)
                       && (i_in_char != NEWLINE_CODE);

    // stalled result stays valid and its last_row flag holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_last))
        else $error("result dropped or changed under stall");

    // a drawn character blocks the command channel
    a_draw_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer && w_draw |=> !i_in_ready)
        else $error("command taken while drawing");

    // commands without results keep the channel open
    a_quick_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer && !w_draw |=> i_in_ready)
        else $error("non-drawing command stalled the channel");

    // no result while product and base address are formed after a drawn character, unless pending
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer && w_draw && !i_out_valid |=> !i_out_valid ##1 !i_out_valid)
        else $error("result before address setup");

endmodule

bind bitmap_font_text_console bftc_chk u_bftc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_in_op     (i_cmd.op),
    .i_in_char   (i_cmd.char_code),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_last  (o_pix.last_row)
);
